// ===== hw/rtl/vpa_pkg.sv =====
// Package for the variable partition allocator: sizes, segment record, action, status and register codes.
// No dependencies.
package vpa_pkg;
  localparam int MaxSegments = 16;
  localparam int AddrBits = 16;
  localparam int IdxBits = $clog2(MaxSegments);
  localparam int CntBits = $clog2(MaxSegments + 1);

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [IdxBits-1:0] idx_t;
  typedef logic [CntBits-1:0] cnt_t;

  typedef struct packed {
    addr_t start;
    addr_t length;
    logic [7:0] owner;
    logic used;
  } seg_t;

  localparam logic [1:0] ActFirst = 2'd0;
  localparam logic [1:0] ActBest = 2'd1;
  localparam logic [1:0] ActNext = 2'd2;
  localparam logic [1:0] ActRelease = 2'd3;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StNoName = 3'd1;
  localparam logic [2:0] StNoFit = 3'd2;
  localparam logic [2:0] StReleaseOs = 3'd3;
  localparam logic [2:0] StNoOwner = 3'd4;
  localparam logic [2:0] StTableFull = 3'd5;

  localparam logic [1:0] RegTotalSize = 2'd0;
  localparam logic [1:0] RegOsSize = 2'd1;
  localparam logic [1:0] RegMinLeftover = 2'd2;
endpackage

// ===== hw/rtl/variable_partition_allocator_top.sv =====
// Variable partition allocator, top level: segment table, scan/shift sequencer.
// Depends on vpa_pkg.
//
// A request is taken when start is high and busy is low; busy then stays high
// until done pulses for one cycle with status, start_address and
// segment_length. The receiver cannot stall: the result beat is there for that
// one cycle only. The sequencer looks at one table entry per cycle through a
// single compare unit, then moves entries one per cycle to open or close a
// gap. A request from owner 0, or a release of owner 1, gets done without
// busy going high, and a register write drops a request in flight. A
// register write rebuilds the table on the next cycle, and busy is high for
// that cycle.
module variable_partition_allocator_top
  import vpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [1:0]  action,
  input  logic [7:0]  owner,
  input  logic [15:0] request_length,
  output logic [2:0]  status,
  output logic [15:0] start_address,
  output logic [15:0] segment_length,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_INS, S_INS_FIX, S_REL_PREV, S_REL_NEXT,
    S_DEL, S_REL_OUT
  } state_t;

  state_t state;
  seg_t tbl [MaxSegments];
  cnt_t count;
  idx_t rover;
  addr_t total_size, os_size, min_leftover;

  logic [1:0] act;
  logic [7:0] own;
  addr_t len;
  cnt_t pos;     // scan step counter
  idx_t pick, cur, del_k;
  logic found;

  // table rebuild lands the cycle after a register write
  logic rebuild_pend;
  logic cfg_hit;

  // one shared compare unit: fit test, best-fit compare or owner match on the current entry
  idx_t scan_i;
  logic [AddrBits:0] need;
  logic fit_ok, better, hit;
  logic [CntBits:0] nf_sum;

  always_comb begin
    nf_sum = {2'b0, rover} + {1'b0, pos} + 1'b1;
    if (act == ActNext) begin
      if (nf_sum >= {1'b0, count}) scan_i = IdxBits'(nf_sum - {1'b0, count});
      else scan_i = IdxBits'(nf_sum);
    end else begin
      scan_i = IdxBits'(pos);
    end
    need = {1'b0, len} + {1'b0, min_leftover};
    fit_ok = !tbl[scan_i].used && ({1'b0, tbl[scan_i].length} >= need);
    better = !found || (tbl[scan_i].length < tbl[pick].length);
    if (act == ActRelease) hit = tbl[scan_i].used && tbl[scan_i].owner == own;
    else hit = fit_ok && (act != ActBest || better);
  end

  addr_t os_eff;
  always_comb os_eff = (os_size > total_size) ? total_size : os_size;

  assign cfg_hit = cfg_we && (cfg_index <= RegMinLeftover);
  assign busy = (state != S_IDLE) || rebuild_pend;

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      done <= 1'b0;
      if (rst) begin
        total_size <= 16'd1024;
        os_size <= 16'd64;
        min_leftover <= '0;
        tbl[0] <= '{start: '0, length: 16'd64, owner: 8'd1, used: 1'b1};
        tbl[1] <= '{start: 16'd64, length: 16'd960, owner: 8'd0, used: 1'b0};
      end else begin
        case (cfg_index)
          RegTotalSize: total_size <= cfg_data;
          RegOsSize: os_size <= cfg_data;
          RegMinLeftover: min_leftover <= cfg_data;
          default: ;
        endcase
      end
      count <= cnt_t'(2);
      rover <= '0;
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          done <= start && !rebuild_pend &&
                  (owner == 8'd0 || (action == ActRelease && owner == 8'd1));
          if (start && !rebuild_pend) begin
            act <= action;
            own <= owner;
            len <= request_length;
            pos <= '0;
            found <= 1'b0;
            pick <= '0;
            if (owner == 8'd0) begin
              status <= StNoName;
              start_address <= '0;
              segment_length <= '0;
            end else if (action == ActRelease && owner == 8'd1) begin
              status <= StReleaseOs;
              start_address <= '0;
              segment_length <= '0;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          done <= 1'b0;
          if (hit) begin
            pick <= scan_i;
            found <= 1'b1;
          end
          pos <= pos + 1'b1;
          if ((hit && act != ActBest) || (pos + 1'b1 >= count)) state <= S_DECIDE;
        end
        S_DECIDE: begin
          done <= !found || (act != ActRelease && count >= cnt_t'(MaxSegments));
          if (!found) begin
            status <= (act == ActRelease) ? StNoOwner : StNoFit;
            start_address <= '0;
            segment_length <= '0;
            state <= S_IDLE;
          end else if (act == ActRelease) begin
            tbl[pick].used <= 1'b0;
            tbl[pick].owner <= '0;
            state <= S_REL_PREV;
          end else if (count >= cnt_t'(MaxSegments)) begin
            status <= StTableFull;
            start_address <= '0;
            segment_length <= '0;
            state <= S_IDLE;
          end else begin
            cur <= IdxBits'(count);
            state <= S_INS;
          end
        end
        S_INS: begin
          done <= 1'b0;
          // shift entries up one slot, top down, one per cycle
          if (cur == pick) begin
            state <= S_INS_FIX;
          end else begin
            tbl[cur] <= tbl[cur - 1'b1];
            cur <= cur - 1'b1;
          end
        end
        S_INS_FIX: begin
          count <= count + 1'b1;
          tbl[pick].length <= len;
          tbl[pick].owner <= own;
          tbl[pick].used <= 1'b1;
          tbl[pick + 1'b1].start <= tbl[pick].start + len;
          tbl[pick + 1'b1].length <= tbl[pick].length - len;
          if (act == ActNext) rover <= pick + 1'b1;
          else if (rover >= pick) rover <= rover + 1'b1;
          status <= StOk;
          start_address <= tbl[pick].start;
          segment_length <= len;
          done <= 1'b1;
          state <= S_IDLE;
        end
        S_REL_PREV: begin
          done <= 1'b0;
          if (pick != '0 && !tbl[pick - 1'b1].used) begin
            tbl[pick - 1'b1].length <= tbl[pick - 1'b1].length + tbl[pick].length;
            del_k <= pick;
            cur <= pick;
            pick <= pick - 1'b1;
            found <= 1'b0;
            state <= S_DEL;
          end else begin
            state <= S_REL_NEXT;
          end
        end
        S_REL_NEXT: begin
          done <= 1'b0;
          if ({1'b0, pick} + 1'b1 < {1'b0, count} && !tbl[pick + 1'b1].used) begin
            tbl[pick].length <= tbl[pick].length + tbl[pick + 1'b1].length;
            del_k <= pick + 1'b1;
            cur <= pick + 1'b1;
            found <= 1'b1;
            state <= S_DEL;
          end else begin
            state <= S_REL_OUT;
          end
        end
        S_DEL: begin
          done <= 1'b0;
          // close the gap at del_k, one entry per cycle
          if ({1'b0, cur} + 1'b1 < {1'b0, count}) begin
            tbl[cur] <= tbl[cur + 1'b1];
            cur <= cur + 1'b1;
          end else begin
            count <= count - 1'b1;
            if (rover >= del_k && rover != '0) rover <= rover - 1'b1;
            state <= found ? S_REL_OUT : S_REL_NEXT;
          end
        end
        S_REL_OUT: begin
          status <= StOk;
          start_address <= tbl[pick].start;
          segment_length <= tbl[pick].length;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          done <= 1'b0;
          state <= S_IDLE;
        end
      endcase
      if (rebuild_pend) begin
        tbl[0] <= '{start: '0, length: os_eff, owner: 8'd1, used: 1'b1};
        tbl[1] <= '{start: os_eff, length: total_size - os_eff, owner: 8'd0,
                    used: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rebuild_pend <= 1'b0;
    else rebuild_pend <= cfg_hit;
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count >= cnt_t'(2) && count <= cnt_t'(MaxSegments))
    else $error("segment count out of range");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_os_entry: assert property (@(posedge clk) disable iff (rst)
    !busy |-> tbl[0].used) else $error("os entry lost");
  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    done && status == StOk && act != ActRelease |-> segment_length == len)
    else $error("granted length mismatch");
`endif

endmodule
